>>> rtl/core/fts_pkg.sv
// Shared types, codes and constants of the FIFO thread scheduler.
`timescale 1ns / 1ps
package fts_pkg;

   localparam int DEF_NUM_THREADS = 16;
   localparam int DEF_NUM_QUEUES  = 32;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_YIELD  = 3'd1;
   localparam logic [2:0] OP_KILL   = 3'd2;
   localparam logic [2:0] OP_EXIT   = 3'd3;
   localparam logic [2:0] OP_SLEEP  = 3'd4;
   localparam logic [2:0] OP_WAKEUP = 3'd5;

   localparam logic [1:0] KIND_ID   = 2'd0;
   localparam logic [1:0] KIND_SELF = 2'd1;
   localparam logic [1:0] KIND_ANY  = 2'd2;

   localparam logic [2:0] TS_READY  = 3'd1;
   localparam logic [2:0] TS_RUN    = 3'd2;
   localparam logic [2:0] TS_SLEEP  = 3'd3;
   localparam logic [2:0] TS_EXITED = 3'd4;
   localparam logic [2:0] TS_EMPTY  = 3'd5;
   localparam logic [2:0] TS_KILLED = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NONE    = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_NOSLOT  = 3'd3;
   localparam logic [2:0] ST_LAST    = 3'd4;

   localparam logic [4:0] CMD_NOP         = 5'd0;
   localparam logic [4:0] CMD_LATCH       = 5'd1;
   localparam logic [4:0] CMD_SCAN_INIT   = 5'd2;
   localparam logic [4:0] CMD_SCAN_NEXT   = 5'd3;
   localparam logic [4:0] CMD_CREATE      = 5'd4;
   localparam logic [4:0] CMD_TGT_HEAD    = 5'd5;
   localparam logic [4:0] CMD_TGT_ID      = 5'd6;
   localparam logic [4:0] CMD_SWEEP_INIT  = 5'd7;
   localparam logic [4:0] CMD_SWEEP       = 5'd8;
   localparam logic [4:0] CMD_UNLINK      = 5'd9;
   localparam logic [4:0] CMD_SWITCH      = 5'd10;
   localparam logic [4:0] CMD_KILL        = 5'd11;
   localparam logic [4:0] CMD_EXIT        = 5'd12;
   localparam logic [4:0] CMD_SLEEP       = 5'd13;
   localparam logic [4:0] CMD_WAKE_SETUP  = 5'd14;
   localparam logic [4:0] CMD_WAKE_POP    = 5'd15;
   localparam logic [4:0] CMD_POP_READY   = 5'd16;
   localparam logic [4:0] CMD_SELF        = 5'd17;
   localparam logic [4:0] CMD_FIN         = 5'd18;

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] target_kind;
      logic [3:0] target_id;
      logic [4:0] queue_id;
      logic       wake_all;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] result_id;
      logic [4:0] woken_count;
      logic [3:0] running_thread;
   } rsp_type;

   typedef struct packed {
      logic [4:0] code;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] target_kind;
      logic       live_full;
      logic       live_le1;
      logic       join_empty;
      logic       rh_null;
      logic       wh_null;
      logic       hit;
      logic       idx_last;
      logic       t_bad;
      logic       cur_ok;
      logic       cur_killed;
      logic       t_in_ready;
      logic       q_bad;
      logic       kill_ok;
      logic       wake_all;
      logic       out_free;
   } stat_type;

endpackage

>>> rtl/core/fifo_thread_scheduler_top.sv
// Top level of the FIFO thread scheduler with numbered wait queues.
//
// One command item enters on the req_ channel (valid/ready) and exactly one
// result item leaves on the rsp_ channel (valid/ready) for each command.
// Commands are create, yield, kill, exit, sleep and wakeup; each result gives
// a status, the chosen thread id, the number of woken threads and the thread
// that runs afterwards.
// The controller works on one item at a time. The free-slot scan, the reclaim
// sweep over the thread slots and a wake-all each walk one thread per cycle,
// and a yield from a killed thread sweeps, wakes its joiners and sweeps again.
// After reset thread 0 runs, every other slot is empty and all queues are
// empty; the block is ready for an item in the first cycle after reset.
// The result sits in an output register; a stalled receiver holds it there,
// the block meanwhile takes and works the next item and waits to deliver it.
`timescale 1ns / 1ps
module fifo_thread_scheduler_top
   import fts_pkg::*;
#(
   parameter int NUM_THREADS = DEF_NUM_THREADS,
   parameter int NUM_QUEUES  = DEF_NUM_QUEUES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   fts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fts_dpath #(
      .NUM_THREADS (NUM_THREADS),
      .NUM_QUEUES  (NUM_QUEUES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/fts_ctrl.sv
// Controller state machine that sequences each scheduler command.
`timescale 1ns / 1ps
module fts_ctrl
   import fts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_CSCAN  = 4'd2;
   localparam logic [3:0] S_YCHK   = 4'd3;
   localparam logic [3:0] S_SWEEP  = 4'd4;
   localparam logic [3:0] S_YPOST  = 4'd5;
   localparam logic [3:0] S_SWITCH = 4'd6;
   localparam logic [3:0] S_ECHK   = 4'd7;
   localparam logic [3:0] S_WAKE   = 4'd8;
   localparam logic [3:0] S_YANY   = 4'd9;
   localparam logic [3:0] S_YPOP   = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [2:0] st_ff, st_in;
   logic       sweep_ret_ff, sweep_ret_in;
   logic       wake_ret_ff, wake_ret_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      sweep_ret_in = sweep_ret_ff;
      wake_ret_in  = wake_ret_ff;
      cmd.code     = CMD_NOP;
      cmd.status   = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            st_in    = ST_INVALID;
            case (stat.operation)
               OP_CREATE: begin
                  if (stat.live_full) begin
                     st_in = ST_NOSLOT;
                  end else begin
                     cmd.code = CMD_SCAN_INIT;
                     state_in = S_CSCAN;
                  end
               end
               OP_YIELD: begin
                  if (stat.target_kind == KIND_SELF) begin
                     cmd.code = CMD_SELF;
                     st_in    = ST_OK;
                  end else if (stat.target_kind == KIND_ANY) begin
                     if (stat.rh_null) begin
                        st_in = ST_NONE;
                     end else begin
                        cmd.code = CMD_TGT_HEAD;
                        state_in = S_YCHK;
                     end
                  end else if (stat.target_kind == KIND_ID) begin
                     cmd.code = CMD_TGT_ID;
                     state_in = S_YCHK;
                  end
               end
               OP_KILL: begin
                  if (stat.kill_ok) begin
                     cmd.code = CMD_KILL;
                     st_in    = ST_OK;
                  end
               end
               OP_EXIT: begin
                  state_in = S_ECHK;
               end
               OP_SLEEP: begin
                  if (!stat.q_bad && stat.cur_ok) begin
                     if (stat.rh_null) begin
                        st_in = ST_NONE;
                     end else begin
                        cmd.code = CMD_SLEEP;
                        state_in = S_YANY;
                     end
                  end
               end
               OP_WAKEUP: begin
                  if (!stat.q_bad) begin
                     cmd.code    = CMD_WAKE_SETUP;
                     wake_ret_in = 1'b0;
                     state_in    = S_WAKE;
                  end
               end
               default: begin
                  st_in = ST_INVALID;
               end
            endcase
         end
         S_CSCAN: begin
            if (stat.hit) begin
               cmd.code = CMD_CREATE;
               st_in    = ST_OK;
               state_in = S_FIN;
            end else if (stat.idx_last) begin
               st_in    = ST_NOSLOT;
               state_in = S_FIN;
            end else begin
               cmd.code = CMD_SCAN_NEXT;
            end
         end
         S_YCHK: begin
            if (stat.t_bad) begin
               st_in    = ST_INVALID;
               state_in = S_FIN;
            end else begin
               cmd.code     = CMD_SWEEP_INIT;
               sweep_ret_in = 1'b0;
               state_in     = S_SWEEP;
            end
         end
         S_SWEEP: begin
            cmd.code = CMD_SWEEP;
            if (stat.idx_last) begin
               state_in = sweep_ret_ff ? S_YPOP : S_YPOST;
            end
         end
         S_YPOST: begin
            if (stat.cur_killed) begin
               state_in = S_ECHK;
            end else begin
               if (stat.t_in_ready) begin
                  cmd.code = CMD_UNLINK;
               end
               state_in = S_SWITCH;
            end
         end
         S_SWITCH: begin
            cmd.code = CMD_SWITCH;
            st_in    = ST_OK;
            state_in = S_FIN;
         end
         S_ECHK: begin
            if (!stat.cur_ok) begin
               st_in    = ST_INVALID;
               state_in = S_FIN;
            end else if (stat.live_le1 && stat.join_empty) begin
               st_in    = ST_LAST;
               state_in = S_FIN;
            end else begin
               cmd.code    = CMD_EXIT;
               wake_ret_in = 1'b1;
               state_in    = stat.join_empty ? S_YANY : S_WAKE;
            end
         end
         S_WAKE: begin
            if (stat.wh_null) begin
               st_in    = ST_OK;
               state_in = wake_ret_ff ? S_YANY : S_FIN;
            end else begin
               cmd.code = CMD_WAKE_POP;
               if (!stat.wake_all) begin
                  st_in    = ST_OK;
                  state_in = wake_ret_ff ? S_YANY : S_FIN;
               end
            end
         end
         S_YANY: begin
            if (stat.rh_null) begin
               st_in    = ST_NONE;
               state_in = S_FIN;
            end else begin
               cmd.code     = CMD_SWEEP_INIT;
               sweep_ret_in = 1'b1;
               state_in     = S_SWEEP;
            end
         end
         S_YPOP: begin
            cmd.code = CMD_POP_READY;
            state_in = S_SWITCH;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.code = CMD_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         st_ff        <= ST_OK;
         sweep_ret_ff <= 1'b0;
         wake_ret_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         sweep_ret_ff <= sweep_ret_in;
         wake_ret_ff  <= wake_ret_in;
      end
   end

endmodule

>>> rtl/core/fts_dpath.sv
// Datapath holding thread states, queue links, queue heads and the result register.
`timescale 1ns / 1ps
module fts_dpath
   import fts_pkg::*;
#(
   parameter int NUM_THREADS = DEF_NUM_THREADS,
   parameter int NUM_QUEUES  = DEF_NUM_QUEUES
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int PW = $clog2(NUM_THREADS + 1);
   localparam int QW = $clog2(NUM_QUEUES);
   localparam int LW = $clog2(NUM_THREADS + 1);
   localparam logic [PW-1:0] NIL = PW'(NUM_THREADS);

   logic [2:0]    ts_ff  [NUM_THREADS];
   logic [PW-1:0] nxt_ff [NUM_THREADS];
   logic [PW-1:0] prv_ff [NUM_THREADS];
   logic [PW-1:0] wh_ff  [NUM_QUEUES];
   logic [PW-1:0] wt_ff  [NUM_QUEUES];
   logic [PW-1:0] rh_ff, rt_ff;
   logic [IW-1:0] run_ff;
   logic [LW-1:0] live_ff;
   logic [LW-1:0] cnt_ff;
   logic [PW-1:0] t_ff;
   logic [IW-1:0] idx_ff;
   logic [QW-1:0] wq_ff;
   logic          all_ff;
   logic [IW-1:0] rid_ff;
   req_type       req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic [IW-1:0] t_ix, tid_ix, wp_id, rh_ix, rt_ix, up_p, up_n;
   logic [PW-1:0] wp_n, p_val, n_val;
   logic [2:0]    cur_st, t_st;
   logic          out_free, run_in_q, idx_in_q;

   assign t_ix     = t_ff[IW-1:0];
   assign tid_ix   = IW'(req_ff.target_id);
   assign rh_ix    = rh_ff[IW-1:0];
   assign rt_ix    = rt_ff[IW-1:0];
   assign wp_id    = wh_ff[wq_ff][IW-1:0];
   assign wp_n     = nxt_ff[wp_id];
   assign p_val    = prv_ff[t_ix];
   assign n_val    = nxt_ff[t_ix];
   assign up_p     = p_val[IW-1:0];
   assign up_n     = n_val[IW-1:0];
   assign cur_st   = ts_ff[run_ff];
   assign t_st     = ts_ff[t_ix];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign run_in_q = 32'(run_ff) < NUM_QUEUES;
   assign idx_in_q = 32'(idx_ff) < NUM_QUEUES;

   always_comb begin
      stat.operation   = req_ff.operation;
      stat.target_kind = req_ff.target_kind;
      stat.live_full   = live_ff >= LW'(NUM_THREADS);
      stat.live_le1    = live_ff <= LW'(1);
      stat.join_empty  = !run_in_q || (wh_ff[QW'(run_ff)] >= NIL);
      stat.rh_null     = rh_ff >= NIL;
      stat.wh_null     = wh_ff[wq_ff] >= NIL;
      stat.hit         = (ts_ff[idx_ff] == TS_EMPTY) || (ts_ff[idx_ff] == TS_EXITED);
      stat.idx_last    = idx_ff == IW'(NUM_THREADS - 1);
      stat.t_bad       = (t_ff >= NIL) ||
                         !((t_st == TS_READY) || (t_st == TS_RUN) || (t_st == TS_KILLED));
      stat.cur_ok      = (cur_st == TS_RUN) || (cur_st == TS_KILLED);
      stat.cur_killed  = cur_st == TS_KILLED;
      stat.t_in_ready  = (t_st == TS_READY) || (t_st == TS_KILLED);
      stat.q_bad       = 32'(req_ff.queue_id) >= NUM_QUEUES;
      stat.kill_ok     = (32'(req_ff.target_id) < NUM_THREADS) && (tid_ix != run_ff) &&
                         (ts_ff[tid_ix] == TS_READY);
      stat.wake_all    = all_ff;
      stat.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            ts_ff[i] <= (i == 0) ? TS_RUN : TS_EMPTY;
         end
         for (int i = 0; i < NUM_QUEUES; i++) begin
            wh_ff[i] <= NIL;
            wt_ff[i] <= NIL;
         end
         rh_ff        <= NIL;
         rt_ff        <= NIL;
         run_ff       <= '0;
         live_ff      <= LW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && cmd.code != CMD_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.code)
            CMD_LATCH: begin
               req_ff <= req_data;
               cnt_ff <= '0;
               rid_ff <= '0;
            end
            CMD_SCAN_INIT: begin
               idx_ff <= '0;
            end
            CMD_SCAN_NEXT: begin
               idx_ff <= idx_ff + IW'(1);
            end
            CMD_CREATE: begin
               if (idx_in_q) begin
                  wh_ff[QW'(idx_ff)] <= NIL;
                  wt_ff[QW'(idx_ff)] <= NIL;
               end
               ts_ff[idx_ff]  <= TS_READY;
               nxt_ff[idx_ff] <= NIL;
               if (rh_ff >= NIL || rt_ff >= NIL) begin
                  prv_ff[idx_ff] <= NIL;
                  rh_ff          <= PW'(idx_ff);
               end else begin
                  prv_ff[idx_ff] <= rt_ff;
                  nxt_ff[rt_ix]  <= PW'(idx_ff);
               end
               rt_ff <= PW'(idx_ff);
               if (live_ff < LW'(NUM_THREADS)) begin
                  live_ff <= live_ff + LW'(1);
               end
               rid_ff <= idx_ff;
            end
            CMD_TGT_HEAD: begin
               t_ff <= rh_ff;
            end
            CMD_TGT_ID: begin
               t_ff <= (32'(req_ff.target_id) < NUM_THREADS) ? PW'(req_ff.target_id) : NIL;
            end
            CMD_SWEEP_INIT: begin
               idx_ff <= IW'(1);
            end
            CMD_SWEEP: begin
               if (ts_ff[idx_ff] == TS_EXITED && idx_ff != run_ff) begin
                  ts_ff[idx_ff] <= TS_EMPTY;
                  if (idx_in_q) begin
                     wh_ff[QW'(idx_ff)] <= NIL;
                     wt_ff[QW'(idx_ff)] <= NIL;
                  end
               end
               idx_ff <= idx_ff + IW'(1);
            end
            CMD_UNLINK: begin
               if (p_val < NIL) begin
                  nxt_ff[up_p] <= n_val;
               end else begin
                  rh_ff <= n_val;
               end
               if (n_val < NIL) begin
                  prv_ff[up_n] <= p_val;
               end else begin
                  rt_ff <= p_val;
               end
            end
            CMD_SWITCH: begin
               if (cur_st == TS_RUN && run_ff != t_ix) begin
                  ts_ff[run_ff]  <= TS_READY;
                  nxt_ff[run_ff] <= NIL;
                  if (rh_ff >= NIL || rt_ff >= NIL) begin
                     prv_ff[run_ff] <= NIL;
                     rh_ff          <= PW'(run_ff);
                  end else begin
                     prv_ff[run_ff] <= rt_ff;
                     nxt_ff[rt_ix]  <= PW'(run_ff);
                  end
                  rt_ff <= PW'(run_ff);
               end
               if (t_st != TS_KILLED) begin
                  ts_ff[t_ix] <= TS_RUN;
               end
               run_ff <= t_ix;
               rid_ff <= t_ix;
            end
            CMD_KILL: begin
               ts_ff[tid_ix] <= TS_KILLED;
               rid_ff        <= tid_ix;
            end
            CMD_EXIT: begin
               ts_ff[run_ff] <= TS_EXITED;
               if (live_ff > '0) begin
                  live_ff <= live_ff - LW'(1);
               end
               wq_ff  <= QW'(run_ff);
               all_ff <= 1'b1;
            end
            CMD_SLEEP: begin
               ts_ff[run_ff]  <= TS_SLEEP;
               nxt_ff[run_ff] <= NIL;
               if (wh_ff[QW'(req_ff.queue_id)] >= NIL || wt_ff[QW'(req_ff.queue_id)] >= NIL)
               begin
                  prv_ff[run_ff]               <= NIL;
                  wh_ff[QW'(req_ff.queue_id)] <= PW'(run_ff);
               end else begin
                  prv_ff[run_ff] <= wt_ff[QW'(req_ff.queue_id)];
                  nxt_ff[wt_ff[QW'(req_ff.queue_id)][IW-1:0]] <= PW'(run_ff);
               end
               wt_ff[QW'(req_ff.queue_id)] <= PW'(run_ff);
               if (live_ff > '0) begin
                  live_ff <= live_ff - LW'(1);
               end
            end
            CMD_WAKE_SETUP: begin
               wq_ff  <= QW'(req_ff.queue_id);
               all_ff <= req_ff.wake_all;
            end
            CMD_WAKE_POP: begin
               if (wp_n >= NIL) begin
                  wh_ff[wq_ff] <= NIL;
                  wt_ff[wq_ff] <= NIL;
               end else begin
                  wh_ff[wq_ff]           <= wp_n;
                  prv_ff[wp_n[IW-1:0]] <= NIL;
               end
               if (ts_ff[wp_id] != TS_KILLED) begin
                  ts_ff[wp_id] <= TS_READY;
               end
               if (live_ff < LW'(NUM_THREADS)) begin
                  live_ff <= live_ff + LW'(1);
               end
               nxt_ff[wp_id] <= NIL;
               if (rh_ff >= NIL || rt_ff >= NIL) begin
                  prv_ff[wp_id] <= NIL;
                  rh_ff         <= PW'(wp_id);
               end else begin
                  prv_ff[wp_id] <= rt_ff;
                  nxt_ff[rt_ix] <= PW'(wp_id);
               end
               rt_ff  <= PW'(wp_id);
               cnt_ff <= cnt_ff + LW'(1);
            end
            CMD_POP_READY: begin
               t_ff <= rh_ff;
               if (nxt_ff[rh_ix] >= NIL) begin
                  rh_ff <= NIL;
                  rt_ff <= NIL;
               end else begin
                  rh_ff                         <= nxt_ff[rh_ix];
                  prv_ff[nxt_ff[rh_ix][IW-1:0]] <= NIL;
               end
            end
            CMD_SELF: begin
               rid_ff <= run_ff;
            end
            CMD_FIN: begin
               if (out_free) begin
                  rsp_valid_ff               <= 1'b1;
                  rsp_data_ff.status         <= cmd.status;
                  rsp_data_ff.result_id      <= (cmd.status == ST_OK) ? 4'(rid_ff) : 4'd0;
                  rsp_data_ff.woken_count    <= 5'(cnt_ff);
                  rsp_data_ff.running_thread <= 4'(run_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
